// File: src/hstcp_pkg.sv
// ----------------------------------------------------------------------------
// hstcp_pkg
// shared types, constants and response tables of the highspeed tcp window engine
// ----------------------------------------------------------------------------
package hstcp_pkg;

  localparam int TABLE_STEPS = 73;
  localparam int IDX_W       = 7;
  localparam int DVD_W       = 40;
  localparam int DVS_W       = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_THRESHOLD    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_TX_ENABLE = 8'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_RETX    = 2'd1;
  localparam logic [1:0] ACT_PENDING = 2'd2;
  localparam logic [1:0] ACT_NEW_SEG = 2'd3;

  localparam logic [15:0] SEG_RESET    = 16'd536;
  localparam logic [7:0]  THR_RESET    = 8'd3;
  localparam logic [31:0] WINDOW_RESET = 32'd536;
  localparam logic [31:0] SSTH_RESET   = 32'd65535;
  localparam logic [31:0] PCT_DIVISOR  = 32'd100;

  // floor(x / 100) as (x * PCT_RECIP) >> 37 for 32-bit x,
  // and as (y * PCT_RECIP_SMALL) >> 19 for y below 8192
  localparam logic [30:0] PCT_RECIP       = 31'd1374389535;
  localparam logic [12:0] PCT_RECIP_SMALL = 13'd5243;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  localparam logic [16:0] STEP_LIMIT [TABLE_STEPS] = '{
    17'd38, 17'd118, 17'd221, 17'd347, 17'd495, 17'd663, 17'd851, 17'd1058,
    17'd1284, 17'd1529, 17'd1793, 17'd2076, 17'd2378, 17'd2699, 17'd3039,
    17'd3399, 17'd3778, 17'd4177, 17'd4596, 17'd5036, 17'd5497, 17'd5979,
    17'd6483, 17'd7009, 17'd7558, 17'd8130, 17'd8726, 17'd9346, 17'd9991,
    17'd10661, 17'd11358, 17'd12082, 17'd12834, 17'd13614, 17'd14424,
    17'd15265, 17'd16137, 17'd17042, 17'd17981, 17'd18955, 17'd19965,
    17'd21013, 17'd22101, 17'd23230, 17'd24402, 17'd25618, 17'd26881,
    17'd28193, 17'd29557, 17'd30975, 17'd32450, 17'd33986, 17'd35586,
    17'd37253, 17'd38992, 17'd40808, 17'd42707, 17'd44694, 17'd46776,
    17'd48961, 17'd51258, 17'd53667, 17'd56230, 17'd58932, 17'd61799,
    17'd64851, 17'd68113, 17'd71617, 17'd75401, 17'd79517, 17'd84035,
    17'd89053, 17'd94717
  };

  localparam logic [5:0] DECREASE_PCT [TABLE_STEPS] = '{
    6'd50, 6'd44, 6'd41, 6'd38, 6'd37, 6'd35, 6'd34, 6'd33, 6'd32, 6'd31,
    6'd30, 6'd29, 6'd28, 6'd28, 6'd27, 6'd27, 6'd26, 6'd26, 6'd25, 6'd25,
    6'd24, 6'd24, 6'd23, 6'd23, 6'd22, 6'd22, 6'd22, 6'd21, 6'd21, 6'd21,
    6'd20, 6'd20, 6'd20, 6'd19, 6'd19, 6'd19, 6'd19, 6'd18, 6'd18, 6'd18,
    6'd17, 6'd17, 6'd17, 6'd17, 6'd16, 6'd16, 6'd16, 6'd16, 6'd15, 6'd15,
    6'd15, 6'd15, 6'd14, 6'd14, 6'd14, 6'd14, 6'd13, 6'd13, 6'd13, 6'd13,
    6'd13, 6'd12, 6'd12, 6'd12, 6'd12, 6'd11, 6'd11, 6'd11, 6'd10, 6'd10,
    6'd10, 6'd10, 6'd9
  };

endpackage

// File: src/hstcp_if.sv
// ----------------------------------------------------------------------------
// hstcp channel interfaces
// ack event, window result and configuration write channels
// ----------------------------------------------------------------------------
interface hstcp_ack_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] ack_seq;
  logic [31:0] head_seq;
  logic [31:0] bytes_in_flight;
  logic [7:0]  dup_count;
  logic [31:0] high_tx_mark;
  logic        data_pending;

  modport source (output valid, func, ack_seq, head_seq, bytes_in_flight, dup_count,
                  high_tx_mark, data_pending, input ready);
  modport sink (input valid, func, ack_seq, head_seq, bytes_in_flight, dup_count,
                high_tx_mark, data_pending, output ready);
endinterface

interface hstcp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] cwnd;
  logic [31:0] ssthresh;
  logic        in_fast_recovery;
  logic [1:0]  action;

  modport source (output valid, cwnd, ssthresh, in_fast_recovery, action, input ready);
  modport sink (input valid, cwnd, ssthresh, in_fast_recovery, action, output ready);
endinterface

interface hstcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/highspeed_tcp_cwnd_engine.sv
// ----------------------------------------------------------------------------
// highspeed_tcp_cwnd_engine
// highspeed tcp congestion window engine with newreno fast recovery
// ----------------------------------------------------------------------------
//  channel  dir   role
//  ack_ch   in    new or duplicate ack event
//  res_ch   out   window, threshold, recovery flag and action
//  cfg      in    register write, always ready
//
//  one request at a time; ack_ch ready only in idle
//  result valid in the cycle after accept for partial ack, inflation and
//  early duplicates; slow start passes grow; a window cut runs the divider,
//  table search, multiply; avoidance growth adds grow and a second division
//  synchronous reset; a result waiting on res_ch holds off the next request
module highspeed_tcp_cwnd_engine (
  input  logic clk,
  input  logic rst,
  hstcp_ack_if.sink   ack_ch,
  hstcp_res_if.source res_ch,
  hstcp_cfg_if.sink   cfg
);
  import hstcp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GROW   = 3'd1;
  localparam logic [2:0] S_DIV_W  = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV_Q  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]  state;
  logic [15:0] segment_size;
  logic [7:0]  retx_threshold;
  logic        limited_tx_enable;
  logic [31:0] window;
  logic [31:0] ssthresh;
  logic        recovering;
  logic [31:0] recover_point;
  logic [1:0]  action;
  logic        cut;
  logic [31:0] w_seg;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [25:0] cut_q;
  logic [6:0]  cut_r;
  logic [31:0] cut_hi;
  logic [12:0] cut_lo;

  div_req_t         div_req;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic [31:0] seg_div;
  logic [31:0] ack_rel;
  logic [31:0] ack_head;
  logic [33:0] partial;
  logic [32:0] full_lim;
  logic [32:0] grow_sum;
  logic [32:0] inc_sum;
  logic [16:0] two_seg;
  logic [31:0] half_flight;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [47:0] mul_out;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [62:0] recip;
  logic [31:0] cut_rem;
  logic [25:0] frac_prod;

  hstcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign seg_div     = (segment_size == '0) ? 32'd1 : {16'b0, segment_size};
  assign ack_rel     = ack_ch.ack_seq - recover_point;
  assign ack_head    = ack_ch.ack_seq - ack_ch.head_seq;
  assign partial     = {2'b00, window} - {{2{ack_head[31]}}, ack_head}
                       + {18'b0, segment_size};
  assign full_lim    = {1'b0, ack_ch.bytes_in_flight} + {17'b0, segment_size};
  assign grow_sum    = {1'b0, window} + {17'b0, segment_size};
  assign inc_sum     = {1'b0, window} + {1'b0, div_q[31:0]};
  assign two_seg     = {segment_size, 1'b0};
  assign half_flight = {1'b0, ack_ch.bytes_in_flight[31:1]};
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid         = mid_sum[IDX_W:1];

  assign mul_a   = {25'b0, lo + 1'b1};
  assign mul_b   = segment_size;
  assign mul_out = mul_a * mul_b;

  // window cut as q * b + (r * b) / 100 with window = 100 * q + r
  assign recip     = window * PCT_RECIP;
  assign cut_rem   = window - ({6'b0, cut_q} * PCT_DIVISOR);
  assign frac_prod = cut_lo * PCT_RECIP_SMALL;

  assign ack_ch.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  assign res_ch.valid            = (state == S_DONE);
  assign res_ch.cwnd             = window;
  assign res_ch.ssthresh         = ssthresh;
  assign res_ch.in_fast_recovery = recovering;
  assign res_ch.action           = action;

  always_comb begin
    div_req = '0;
    unique case (state)
      S_IDLE: begin
        div_req.dividend = {8'b0, window};
        div_req.divisor  = seg_div;
        div_req.start    = ack_ch.valid && ack_ch.func &&
                           (ack_ch.dup_count == retx_threshold) && !recovering;
      end
      S_GROW: begin
        div_req.dividend = {8'b0, window};
        div_req.divisor  = seg_div;
        div_req.start    = !(window < ssthresh);
      end
      S_MUL: begin
        div_req.dividend = mul_out[DVD_W-1:0];
        div_req.divisor  = (window == '0) ? 32'd1 : window;
        div_req.start    = !cut;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size      <= SEG_RESET;
      retx_threshold    <= THR_RESET;
      limited_tx_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SEGMENT_SIZE:      segment_size      <= cfg.data;
        CFG_RETX_THRESHOLD:    retx_threshold    <= cfg.data[7:0];
        CFG_LIMITED_TX_ENABLE: limited_tx_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window        <= WINDOW_RESET;
      ssthresh      <= SSTH_RESET;
      recovering    <= 1'b0;
      recover_point <= '0;
      action        <= ACT_NONE;
      cut           <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ack_ch.valid) begin
            action <= ACT_NONE;
            cut    <= 1'b0;
            state  <= S_DONE;
            if (!ack_ch.func) begin
              if (recovering && ack_rel[31]) begin
                if (partial[33]) begin
                  window <= '0;
                end else if (partial[32]) begin
                  window <= '1;
                end else begin
                  window <= partial[31:0];
                end
                action <= ACT_RETX;
              end else begin
                if (recovering) begin
                  window     <= (full_lim < {1'b0, ssthresh}) ? full_lim[31:0] : ssthresh;
                  recovering <= 1'b0;
                end
                state <= S_GROW;
              end
            end else if ((ack_ch.dup_count == retx_threshold) && !recovering) begin
              ssthresh      <= ({15'b0, two_seg} > half_flight) ? {15'b0, two_seg}
                                                                 : half_flight;
              recover_point <= ack_ch.high_tx_mark;
              recovering    <= 1'b1;
              action        <= ACT_RETX;
              cut           <= 1'b1;
              state         <= S_DIV_W;
            end else if (recovering) begin
              window <= grow_sum[32] ? '1 : grow_sum[31:0];
              action <= ACT_PENDING;
            end else if (limited_tx_enable && ack_ch.data_pending) begin
              action <= ACT_NEW_SEG;
            end
          end
        end
        S_GROW: begin
          if (window < ssthresh) begin
            window <= grow_sum[32] ? '1 : grow_sum[31:0];
            state  <= S_DONE;
          end else begin
            state <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            w_seg <= div_q[31:0];
            cut_q <= recip[62:37];
            lo    <= '0;
            hi    <= IDX_W'(TABLE_STEPS - 1);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          cut_r <= cut_rem[6:0];
          if (lo < hi) begin
            if (w_seg <= {15'b0, STEP_LIMIT[mid]}) begin
              hi <= mid;
            end else begin
              lo <= mid + 1'b1;
            end
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cut_hi <= {6'b0, cut_q} * {26'b0, DECREASE_PCT[lo]};
          cut_lo <= {6'b0, cut_r} * {7'b0, DECREASE_PCT[lo]};
          state  <= S_DIV_Q;
        end
        S_DIV_Q: begin
          if (cut) begin
            window <= cut_hi + {25'b0, frac_prod[25:19]};
            state  <= S_DONE;
          end else if (div_done) begin
            window <= inc_sum[32] ? '1 : inc_sum[31:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/hstcp_div.sv
// ----------------------------------------------------------------------------
// hstcp_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hstcp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  hstcp_pkg::div_req_t        req,
  output logic                       done,
  output logic [hstcp_pkg::DVD_W-1:0] quotient
);
  import hstcp_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] den;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted  = {rem, dvd[DVD_W-1]};
  assign ge       = shifted >= {1'b0, den};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      den <= req.divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= ge ? DVS_W'(shifted - {1'b0, den}) : shifted[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

endmodule
